// ===== rtl/mccw_pkg.sv =====
// Package for the MCU centre-crop writer: register indexes, field widths,
// reset values and small elaboration helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mccw_pkg;

  localparam int MAX_MCUS_PER_AXIS_DEF = 128;
  localparam int MAX_OUT_DIM_DEF       = 1024;

  // Field widths of the stream payloads
  localparam int MCU_IDX_W = 7;
  localparam int COLOR_W   = 16;
  localparam int ADDR_W    = 20;
  localparam int PIX_W     = 11;  // pixel coordinate inside the cropped output image

  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 3;

  // Reset values of the configuration registers
  localparam int RST_OUT_WIDTH  = 96;
  localparam int RST_OUT_HEIGHT = 96;
  localparam int RST_MCUS_ROW   = 20;
  localparam int RST_MCUS_COL   = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUT_WIDTH      = 3'd0,
    REG_OUT_HEIGHT     = 3'd1,
    REG_MCU_WIDTH_SEL  = 3'd2,
    REG_MCU_HEIGHT_SEL = 3'd3,
    REG_MCUS_PER_ROW   = 3'd4,
    REG_MCUS_PER_COL   = 3'd5
  } cfg_reg_t;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  function automatic int imin(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mccw_axis.sv =====
// Crop window along one axis: first kept MCU and one past the last kept MCU.
// Registered from the configuration registers; uses mccw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mccw_axis #(
  parameter int OW_W = 11,
  parameter int MC_W = 8
) (
  input  wire logic                                  clk,
  input  wire logic [OW_W-1:0]                       out_dim,
  input  wire logic                                  sel,
  input  wire logic [MC_W-1:0]                       mcus,
  output logic [MC_W-1:0]                            start,
  output logic [mccw_pkg::imax(MC_W, OW_W-3):0]      limit
);
  import mccw_pkg::*;

  localparam int KW = OW_W - 3;
  localparam int LW = imax(MC_W, KW) + 1;

  logic [KW-1:0]   keep;
  logic [MC_W-1:0] skip;
  logic [MC_W-1:0] start_next;
  logic [LW-1:0]   limit_next;

  always_comb begin
    keep = sel ? KW'(out_dim >> 4) : KW'(out_dim >> 3);
    // clamp a negative skip count to zero
    if (LW'(mcus) > LW'(keep)) begin
      skip = MC_W'(LW'(mcus) - LW'(keep));
    end else begin
      skip = '0;
    end
    start_next = skip >> 1;
    limit_next = LW'(start_next) + LW'(keep);
  end

  // Registered. The user must make writes only while idle; not enforced.
  always_ff @(posedge clk) begin
    start <= start_next;
    limit <= limit_next;
  end

endmodule

`default_nettype wire

// ===== rtl/mcu_center_crop_writer.sv =====
// MCU centre-crop writer: turns MCU-ordered pixels into frame-buffer writes.
// An input transfer loads the input register; a kept pixel then loads the result register behind m_tvalid.
// Throughput: one pixel per cycle while m_tready does not stall; pixels outside the kept window give no transfer.
// The address path is one 11-bit by out_width multiply plus an add per pixel.
// Reset (rst, synchronous): registers return to 96, 96, 1, 1 (16-pixel MCUs), 20, 15; counters clear.
// Depends on mccw_pkg and mccw_axis.
`timescale 1ns / 1ps
`default_nettype none

module mcu_center_crop_writer #(
  parameter int MAX_MCUS_PER_AXIS = mccw_pkg::MAX_MCUS_PER_AXIS_DEF,
  parameter int MAX_OUT_DIM       = mccw_pkg::MAX_OUT_DIM_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // mcu_x [6:0], mcu_y [13:7], pixel_color [29:14]
  input  wire logic [31:0]                     s_tdata,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // write_addr [19:0], pixel_out [35:20]
  output logic [39:0]                          m_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  input  wire logic                            cfg_we,
  input  wire logic [mccw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mccw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mccw_pkg::*;

  localparam int OW_W = $clog2(MAX_OUT_DIM + 1);
  localparam int MC_W = $clog2(MAX_MCUS_PER_AXIS + 1);
  localparam int LW   = imax(MC_W, OW_W - 3) + 1;
  localparam int CW   = imax(LW, MCU_IDX_W);
  localparam int AW   = imax(PIX_W + OW_W + 1, ADDR_W);

  // Configuration registers
  logic [OW_W-1:0] out_width;
  logic [OW_W-1:0] out_height;
  logic            mcu_width_sel;
  logic            mcu_height_sel;
  logic [MC_W-1:0] mcus_per_row;
  logic [MC_W-1:0] mcus_per_col;

  logic [OW_W-1:0] dim_sat;
  logic [MC_W-1:0] mcus_sat;

  always_comb begin
    if (32'(cfg_data) > 32'(MAX_OUT_DIM)) begin
      dim_sat = OW_W'(MAX_OUT_DIM);
    end else begin
      dim_sat = OW_W'(cfg_data);
    end
    if (32'(cfg_data[7:0]) > 32'(MAX_MCUS_PER_AXIS)) begin
      mcus_sat = MC_W'(MAX_MCUS_PER_AXIS);
    end else begin
      mcus_sat = MC_W'(cfg_data[7:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_width      <= OW_W'(imin(RST_OUT_WIDTH, MAX_OUT_DIM));
      out_height     <= OW_W'(imin(RST_OUT_HEIGHT, MAX_OUT_DIM));
      mcu_width_sel  <= 1'b1;
      mcu_height_sel <= 1'b1;
      mcus_per_row   <= MC_W'(imin(RST_MCUS_ROW, MAX_MCUS_PER_AXIS));
      mcus_per_col   <= MC_W'(imin(RST_MCUS_COL, MAX_MCUS_PER_AXIS));
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_OUT_WIDTH:      out_width      <= dim_sat;
        REG_OUT_HEIGHT:     out_height     <= dim_sat;
        REG_MCU_WIDTH_SEL:  mcu_width_sel  <= cfg_data[0];
        REG_MCU_HEIGHT_SEL: mcu_height_sel <= cfg_data[0];
        REG_MCUS_PER_ROW:   mcus_per_row   <= mcus_sat;
        REG_MCUS_PER_COL:   mcus_per_col   <= mcus_sat;
        default: ;
      endcase
    end
  end

  // Crop windows
  logic [MC_W-1:0] start_x;
  logic [MC_W-1:0] start_y;
  logic [LW-1:0]   limit_x;
  logic [LW-1:0]   limit_y;

  mccw_axis #(.OW_W(OW_W), .MC_W(MC_W)) u_axis_x (
    .clk     (clk),
    .out_dim (out_width),
    .sel     (mcu_width_sel),
    .mcus    (mcus_per_row),
    .start   (start_x),
    .limit   (limit_x)
  );

  mccw_axis #(.OW_W(OW_W), .MC_W(MC_W)) u_axis_y (
    .clk     (clk),
    .out_dim (out_height),
    .sel     (mcu_height_sel),
    .mcus    (mcus_per_col),
    .start   (start_y),
    .limit   (limit_y)
  );

  // Handshake
  logic in_acc;
  logic out_free;
  logic s1_adv;
  logic hit;

  logic                 s1_valid;
  logic [MCU_IDX_W-1:0] s1_x;
  logic [MCU_IDX_W-1:0] s1_y;
  logic [COLOR_W-1:0]   s1_color;
  logic [3:0]           s1_row;
  logic [3:0]           s1_col;

  logic [3:0] row_in_mcu;
  logic [3:0] col_in_mcu;
  logic [3:0] row_in_mcu_next;
  logic [3:0] col_in_mcu_next;

  logic                 m_valid;
  logic [ADDR_W-1:0]    m_addr;
  logic [COLOR_W-1:0]   m_pix;

  assign out_free = !m_valid || m_tready;
  assign s1_adv   = s1_valid && (!hit || out_free);
  assign s_tready = !s1_valid || s1_adv;
  assign in_acc   = s_tvalid && s_tready;

  // Position counter inside the MCU; a counter at or past a shrunk size wraps
  always_comb begin
    row_in_mcu_next = row_in_mcu;
    col_in_mcu_next = col_in_mcu + 4'd1;
    if (({1'b0, col_in_mcu} + 5'd1) >= (mcu_width_sel ? 5'd16 : 5'd8)) begin
      col_in_mcu_next = '0;
      if (({1'b0, row_in_mcu} + 5'd1) >= (mcu_height_sel ? 5'd16 : 5'd8)) begin
        row_in_mcu_next = '0;
      end else begin
        row_in_mcu_next = row_in_mcu + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_in_mcu <= '0;
      col_in_mcu <= '0;
      s1_valid   <= 1'b0;
    end else begin
      if (in_acc) begin
        row_in_mcu <= row_in_mcu_next;
        col_in_mcu <= col_in_mcu_next;
        s1_valid   <= 1'b1;
      end else if (s1_adv) begin
        s1_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_x     <= s_tdata[6:0];
      s1_y     <= s_tdata[13:7];
      s1_color <= s_tdata[29:14];
      s1_row   <= row_in_mcu;
      s1_col   <= col_in_mcu;
    end
  end

  // Window test and address
  logic                 in_x;
  logic                 in_y;
  logic [MCU_IDX_W-1:0] x_rel;
  logic [MCU_IDX_W-1:0] y_rel;
  logic [PIX_W-1:0]     x_pix;
  logic [PIX_W-1:0]     y_pix;
  logic [AW-1:0]        addr_full;

  always_comb begin
    in_x  = (CW'(s1_x) >= CW'(start_x)) && (CW'(s1_x) < CW'(limit_x));
    in_y  = (CW'(s1_y) >= CW'(start_y)) && (CW'(s1_y) < CW'(limit_y));
    hit   = in_x && in_y;
    x_rel = MCU_IDX_W'(CW'(s1_x) - CW'(start_x));
    y_rel = MCU_IDX_W'(CW'(s1_y) - CW'(start_y));
    x_pix = (mcu_width_sel ? {x_rel, 4'b0} : {1'b0, x_rel, 3'b0}) + PIX_W'(s1_col);
    y_pix = (mcu_height_sel ? {y_rel, 4'b0} : {1'b0, y_rel, 3'b0}) + PIX_W'(s1_row);
    addr_full = AW'(y_pix) * AW'(out_width) + AW'(x_pix);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (s1_adv && hit) begin
      m_valid <= 1'b1;
    end else if (m_tready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && hit) begin
      m_addr <= addr_full[ADDR_W-1:0];
      m_pix  <= s1_color;
    end
  end

  assign m_tvalid = m_valid;
  assign m_tdata  = {4'b0, m_pix, m_addr};

  // A stalled input side means a pixel is held in the input register.
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> s1_valid)
    else $error("input side stalled with an empty input register");

  // The column counter steps by one or wraps to zero on every transfer.
  a_col_step: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (col_in_mcu == 4'd0) || (col_in_mcu == 4'($past(col_in_mcu) + 4'd1)))
    else $error("column counter jumped");

  // Without an input transfer the position counter holds.
  a_cnt_hold: assert property (@(posedge clk) disable iff (rst)
    !in_acc |=> $stable(col_in_mcu) && $stable(row_in_mcu))
    else $error("position counter moved without a transfer");

  // A kept pixel leaving the input register lands in the result register.
  a_result_load: assert property (@(posedge clk) disable iff (rst)
    s1_adv && hit |=> m_valid && (m_addr == $past(addr_full[ADDR_W-1:0])))
    else $error("kept pixel not loaded into the result register");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for mcu_center_crop_writer: streams MCU-ordered pixels
// through several crop settings and checks every frame-buffer write.
// Depends on mccw_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb;
  import mccw_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 300;
  // Unused register slots; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
  } fb_write_t;

  // Crop window model plus the queue of frame-buffer writes still owed
  class crop_scoreboard;
    bit [10:0] width_q, height_q;
    bit        wsel, hsel;
    bit [7:0]  mcus_row, mcus_col;
    bit [3:0]  row_pos, col_pos;
    fb_write_t pending_writes[$];
    int        mismatches;

    function new();
      width_q    = 11'(RST_OUT_WIDTH);
      height_q   = 11'(RST_OUT_HEIGHT);
      wsel       = 1'b1;
      hsel       = 1'b1;
      mcus_row   = 8'(RST_MCUS_ROW);
      mcus_col   = 8'(RST_MCUS_COL);
      row_pos    = '0;
      col_pos    = '0;
      mismatches = 0;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_OUT_WIDTH:      width_q  = (val > MAX_OUT_DIM_DEF) ? 11'(MAX_OUT_DIM_DEF) : val;
        REG_OUT_HEIGHT:     height_q = (val > MAX_OUT_DIM_DEF) ? 11'(MAX_OUT_DIM_DEF) : val;
        REG_MCU_WIDTH_SEL:  wsel     = val[0];
        REG_MCU_HEIGHT_SEL: hsel     = val[0];
        REG_MCUS_PER_ROW:   mcus_row = (val[7:0] > MAX_MCUS_PER_AXIS_DEF) ?
                                       8'(MAX_MCUS_PER_AXIS_DEF) : val[7:0];
        REG_MCUS_PER_COL:   mcus_col = (val[7:0] > MAX_MCUS_PER_AXIS_DEF) ?
                                       8'(MAX_MCUS_PER_AXIS_DEF) : val[7:0];
        default: ;
      endcase
    endfunction

    // First kept MCU and number kept along one axis; skip clamps at zero
    function void axis_span(input int dim, input bit sel, input int mcus,
                            output int first, output int keep);
      keep  = dim >> (sel ? 4 : 3);
      first = (mcus > keep) ? (mcus - keep) / 2 : 0;
    endfunction

    function void note_pixel(input bit [6:0] mx, input bit [6:0] my, input bit [15:0] color);
      int        fx, kx, fy, ky, mw, mh, xi, yi;
      bit [31:0] x, y, a;
      fb_write_t w;
      axis_span(width_q, wsel, mcus_row, fx, kx);
      axis_span(height_q, hsel, mcus_col, fy, ky);
      mw = wsel ? 16 : 8;
      mh = hsel ? 16 : 8;
      xi = mx;
      yi = my;
      if (xi >= fx && xi < fx + kx && yi >= fy && yi < fy + ky) begin
        y = (yi - fy) * mh + row_pos;
        x = (xi - fx) * mw + col_pos;
        a = y * width_q + x;
        w.addr  = a[ADDR_W-1:0];
        w.color = color;
        pending_writes.push_back(w);
      end
      // A counter left beyond a shrunk MCU wraps on its next step
      if (col_pos + 1 >= mw) begin
        col_pos = '0;
        if (row_pos + 1 >= mh) row_pos = '0;
        else row_pos = row_pos + 4'd1;
      end else begin
        col_pos = col_pos + 4'd1;
      end
    endfunction

    function void check_write(input logic [39:0] data);
      fb_write_t w;
      if (pending_writes.size() == 0) begin
        $error("unexpected write: write_addr %0d pixel_out %h", data[19:0], data[35:20]);
        mismatches++;
        return;
      end
      w = pending_writes.pop_front();
      if (data[19:0] !== w.addr) begin
        $error("write_addr: expected %0d, actual %0d", w.addr, data[19:0]);
        mismatches++;
      end
      if (data[35:20] !== w.color) begin
        $error("pixel_out: expected %h, actual %h", w.color, data[35:20]);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic [31:0]           s_tdata   = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [39:0]           m_tdata;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  crop_scoreboard sb;
  bit gaps_on      = 1'b1;
  bit calm         = 1'b0;
  bit hold_off_req = 1'b0;

  mcu_center_crop_writer u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("mcu_center_crop_writer verification failed");
    $finish;
  end

  // Receiver: random stalls, one long hold-off on request, none when calm
  initial begin
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_write(m_tdata);
  end

  task automatic send_pixel(input bit [6:0] mx, input bit [6:0] my, input bit [15:0] color);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, color, my, mx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_pixel(mx, my, color);
  endtask

  task automatic send_run(input bit [6:0] mx, input bit [6:0] my, input int n);
    for (int i = 0; i < n; i++) send_pixel(mx, my, 16'($urandom));
  endtask

  // Leaves cfg_we high; the caller drops it after the last write
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic configure(input bit [10:0] ow, input bit [10:0] oh, input bit ws,
                           input bit hs, input bit [10:0] mr, input bit [10:0] mc,
                           input bit spare);
    put_reg(REG_OUT_WIDTH, ow);
    put_reg(REG_OUT_HEIGHT, oh);
    put_reg(REG_MCU_WIDTH_SEL, 11'(ws));
    put_reg(REG_MCU_HEIGHT_SEL, 11'(hs));
    put_reg(REG_MCUS_PER_ROW, mr);
    put_reg(REG_MCUS_PER_COL, mc);
    if (spare) begin
      put_reg(REG_UNUSED_A, 11'h7FF);
      put_reg(REG_UNUSED_B, 11'h000);
    end
    cfg_we <= 1'b0;
  endtask

  // Stop offering, wait for every owed write, then let the pipeline settle
  task automatic drain();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (sb.pending_writes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly inside the window, sometimes on its border or anywhere
  function automatic int pick_index(input int first, input int keep);
    int last;
    last = (first + keep - 1 > 127) ? 127 : first + keep - 1;
    if (keep == 0 || $urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 2))
        0:       return $urandom_range(0, 127);
        1:       return (first > 0) ? first - 1 : 0;
        default: return (first + keep > 127) ? 127 : first + keep;
      endcase
    end
    return $urandom_range(first, last);
  endfunction

  task automatic random_traffic(input int budget);
    int sent, fx, kx, fy, ky, mw, mh, pos, n, r;
    bit [6:0] mx, my;
    sent = 0;
    while (sent < budget) begin
      sb.axis_span(sb.width_q, sb.wsel, sb.mcus_row, fx, kx);
      sb.axis_span(sb.height_q, sb.hsel, sb.mcus_col, fy, ky);
      mw = sb.wsel ? 16 : 8;
      mh = sb.hsel ? 16 : 8;
      pos = sb.row_pos * mw + sb.col_pos;
      gaps_on = !calm && ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 9);
      if (r < 7) begin
        // finish the current MCU with one MCU index
        mx = 7'(pick_index(fx, kx));
        my = 7'(pick_index(fy, ky));
        n  = (mw * mh > pos) ? mw * mh - pos : 1;
      end else if (r < 9) begin
        mx = 7'($urandom_range(0, 127));
        my = 7'($urandom_range(0, 127));
        n  = 1;
      end else begin
        // broken MCU: cut short part way through
        mx = 7'(pick_index(fx, kx));
        my = 7'(pick_index(fy, ky));
        n  = $urandom_range(1, mw * mh / 2);
      end
      // stay within the item budget of this stretch
      if (n > budget - sent) n = budget - sent;
      send_run(mx, my, n);
      sent += n;
    end
  endtask

  initial begin
    int n;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: window is MCUs 7..12 across, 4..9 down
    send_pixel(7'd0, 7'd0, 16'h0000);
    send_pixel(7'd127, 7'd127, 16'hFFFF);
    send_pixel(7'd7, 7'd4, 16'hAAAA);
    send_pixel(7'd12, 7'd9, 16'h5555);
    send_pixel(7'd6, 7'd4, 16'h1234);
    send_pixel(7'd13, 7'd4, 16'h4321);
    send_pixel(7'd7, 7'd3, 16'h8001);
    send_pixel(7'd7, 7'd10, 16'h7FFE);
    send_pixel(7'd12, 7'd4, 16'hF00F);
    send_pixel(7'd7, 7'd9, 16'h0FF0);
    send_pixel(7'd127, 7'd0, 16'hC3C3);
    send_pixel(7'd0, 7'd127, 16'h3C3C);
    random_traffic(50);
    drain();

    // Smallest window: one 8x8 MCU; spare register slots written too
    configure(11'd8, 11'd8, 1'b0, 1'b0, 11'd1, 11'd1, 1'b1);
    send_pixel(7'd0, 7'd0, 16'hFFFF);
    send_pixel(7'd1, 7'd0, 16'h0000);
    send_pixel(7'd0, 7'd1, 16'hFFFF);
    send_pixel(7'd0, 7'd0, 16'h0001);
    random_traffic(50);
    drain();

    // Full frame kept; hold the receiver off while pixels keep coming
    configure(11'd1024, 11'd1024, 1'b0, 1'b0, 11'd128, 11'd128, 1'b0);
    hold_off_req = 1'b1;
    gaps_on = 1'b0;
    send_run(7'd127, 7'd127, 48);
    random_traffic(80);
    drain();

    // Oversized writes saturate; 16x16 MCUs
    configure(11'h7FF, 11'h7FF, 1'b1, 1'b1, 11'h1FF, 11'h0FF, 1'b0);
    random_traffic(80);
    // park the counter at row 10, column 12 before the MCU shrinks to 8x8
    n = (172 - (sb.row_pos * 16 + sb.col_pos) + 256) % 256;
    send_run(7'd40, 7'd40, n);
    drain();

    // Empty window on both axes
    configure(11'd0, 11'd0, 1'b0, 1'b0, 11'd0, 11'd0, 1'b0);
    random_traffic(40);
    drain();

    // More MCUs kept than the image holds: window starts at zero
    configure(11'd200, 11'd120, 1'b0, 1'b0, 11'd10, 11'h105, 1'b0);
    send_pixel(7'd0, 7'd0, 16'h00FF);
    send_pixel(7'd24, 7'd14, 16'hFF00);
    send_pixel(7'd25, 7'd0, 16'h0F0F);
    send_pixel(7'd0, 7'd15, 16'hF0F0);
    random_traffic(80);
    drain();

    repeat (2) begin
      configure(11'($urandom_range(8, 1024)), 11'($urandom_range(8, 1024)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                11'($urandom_range(1, 128)), 11'($urandom_range(1, 128)), 1'b0);
      random_traffic(70);
      drain();
    end

    // Closing stretch at full rate on both sides
    calm = 1'b1;
    configure(11'($urandom_range(8, 1024)), 11'($urandom_range(8, 1024)),
              1'b0, 1'b0, 11'($urandom_range(1, 128)), 11'($urandom_range(1, 128)), 1'b0);
    random_traffic(100);
    drain();

    if (sb.pending_writes.size() != 0) begin
      $error("%0d expected writes never arrived", sb.pending_writes.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("mcu_center_crop_writer verification clean");
    end else begin
      $display("mcu_center_crop_writer verification failed");
    end
    $finish;
  end

endmodule
